// ----- hdl/fmacl_pkg.sv -----
package fmacl_pkg;

    localparam int TABLE_DEPTH_DEF = 32;

    localparam logic [1:0] MODE_CLEAR  = 2'd0;
    localparam logic [1:0] MODE_APPEND = 2'd1;
    localparam logic [1:0] MODE_CHECK  = 2'd2;

    localparam logic [1:0] KIND_READ     = 2'd0;
    localparam logic [1:0] KIND_WRITE    = 2'd1;
    localparam logic [1:0] KIND_REGISTER = 2'd2;

    localparam int PERMIT_READ     = 0;
    localparam int PERMIT_WRITE    = 1;
    localparam int PERMIT_REGISTER = 2;

    typedef enum logic {
        ST_IDLE,
        ST_WALK
    } t_state;

    typedef struct packed {
        logic [31:0] address;
        logic [31:0] netmask;
        logic [2:0]  permits;
    } t_entry;

    typedef struct packed {
        logic allowed;
        logic matched;
        logic status;
    } t_result;

endpackage

// ----- hdl/fmacl_if.sv -----
interface fmacl_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic [31:0] rule_address;
    logic [31:0] rule_netmask;
    logic [2:0]  rule_permits;
    logic [31:0] query_address;
    logic [1:0]  perm_kind;
    logic        user_exempt;

    modport source (
        output valid, mode, rule_address, rule_netmask, rule_permits,
               query_address, perm_kind, user_exempt,
        input  ready
    );
    modport sink (
        input  valid, mode, rule_address, rule_netmask, rule_permits,
               query_address, perm_kind, user_exempt,
        output ready
    );
endinterface

interface fmacl_rsp_if;
    logic valid;
    logic ready;
    logic allowed;
    logic matched;
    logic status;

    modport source (
        output valid, allowed, matched, status,
        input  ready
    );
    modport sink (
        input  valid, allowed, matched, status,
        output ready
    );
endinterface

// ----- hdl/fmacl_ram.sv -----
module fmacl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- hdl/fmacl_ctrl.sv -----
module fmacl_ctrl
    import fmacl_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
    localparam int CW = $clog2(TABLE_DEPTH + 1)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    fmacl_req_if.sink     i_req,
    fmacl_rsp_if.source   o_rsp,
    output logic          o_wr_en,
    output logic [AW-1:0] o_wr_addr,
    output t_entry        o_wr_data,
    output logic          o_rd_en,
    output logic [AW-1:0] o_rd_addr,
    input  t_entry        i_rd_data
);

    t_state        r_state, n_state;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [CW-1:0] r_idx, n_idx;
    logic          r_pend, n_pend;
    logic [31:0]   r_query, n_query;
    logic [1:0]    r_kind, n_kind;
    logic          r_out_valid, n_out_valid;
    t_result       r_out, n_out;

    logic accept;
    logic exempt_grant;
    logic table_full;
    logic issue;
    logic hit;
    logic granted;
    logic walk_done;

    assign i_req.ready  = (r_state == ST_IDLE) && (!r_out_valid || o_rsp.ready);
    assign accept       = i_req.valid && i_req.ready;
    assign exempt_grant = i_req.user_exempt && (i_req.perm_kind != KIND_REGISTER);
    assign table_full   = (r_cnt == CW'(TABLE_DEPTH));

    // Reads go out for the stored rules in turn; each compare runs in the cycle after its read.
    assign issue     = (r_state == ST_WALK) && (r_idx < r_cnt);
    assign hit       = ((i_rd_data.address ^ r_query) & i_rd_data.netmask) == 32'd0;
    assign walk_done = (r_pend && hit) || (!r_pend && !issue);

    always_comb begin
        case (r_kind)
            KIND_READ:     granted = i_rd_data.permits[PERMIT_READ];
            KIND_WRITE:    granted = i_rd_data.permits[PERMIT_WRITE];
            KIND_REGISTER: granted = i_rd_data.permits[PERMIT_REGISTER];
            default:       granted = 1'b0;
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept && i_req.mode == MODE_CHECK && !exempt_grant
                        && r_cnt != '0) begin
                    n_state = ST_WALK;
                end
            end
            ST_WALK: begin
                if (walk_done) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_cnt       = r_cnt;
        n_idx       = r_idx;
        n_pend      = 1'b0;
        n_query     = r_query;
        n_kind      = r_kind;
        n_out_valid = r_out_valid && !o_rsp.ready;
        n_out       = r_out;
        o_wr_en     = 1'b0;
        o_wr_addr   = r_cnt[AW-1:0];
        o_wr_data   = '{address: i_req.rule_address,
                        netmask: i_req.rule_netmask,
                        permits: i_req.rule_permits};
        o_rd_en     = 1'b0;
        o_rd_addr   = r_idx[AW-1:0];

        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_out_valid = 1'b1;
                    n_out       = '0;
                    case (i_req.mode)
                        MODE_CLEAR: begin
                            n_cnt = '0;
                        end
                        MODE_APPEND: begin
                            if (table_full) begin
                                n_out.status = 1'b1;
                            end else begin
                                o_wr_en = 1'b1;
                                n_cnt   = r_cnt + CW'(1);
                            end
                        end
                        MODE_CHECK: begin
                            if (exempt_grant) begin
                                n_out.allowed = 1'b1;
                            end else if (r_cnt != '0) begin
                                n_out_valid = 1'b0;
                                n_idx       = '0;
                                n_query     = i_req.query_address;
                                n_kind      = i_req.perm_kind;
                            end
                        end
                        default: begin
                            n_out = '0;
                        end
                    endcase
                end
            end
            ST_WALK: begin
                o_rd_en = issue;
                n_pend  = issue;
                if (issue) begin
                    n_idx = r_idx + CW'(1);
                end
                if (walk_done) begin
                    n_out_valid = 1'b1;
                    n_out       = '0;
                    if (r_pend) begin
                        n_out.matched = 1'b1;
                        n_out.allowed = granted;
                    end
                end
            end
            default: begin
                n_out_valid = r_out_valid;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx   <= n_idx;
        r_query <= n_query;
        r_kind  <= n_kind;
        r_out   <= n_out;
    end

    assign o_rsp.valid   = r_out_valid;
    assign o_rsp.allowed = r_out.allowed;
    assign o_rsp.matched = r_out.matched;
    assign o_rsp.status  = r_out.status;

endmodule

// ----- hdl/first_match_ip_access_list_unit.sv -----
// Ordered IPv4 access list with first-match lookup. Mode 0 empties the list,
// mode 1 appends a rule (address, mask, read/write/register permits) or
// reports status 1 when the list is full, and mode 2 checks a query address
// for one permission kind. Clears, appends, exempt grants and checks against
// an empty list are answered straight from the idle state, without a walk.
// Any other check walks the rules in order through the single read port of
// the rule RAM, one rule per cycle, and stops at the first match; with no
// match it returns once all N stored rules have been read. One request is
// handled at a time; the next one is taken once the result register is free
// or is being drained.
module first_match_ip_access_list_unit
    import fmacl_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    fmacl_req_if.sink   i_req,
    fmacl_rsp_if.source o_rsp
);

    logic          wr_en;
    logic [AW-1:0] wr_addr;
    t_entry        wr_data;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    t_entry        rd_data;

    fmacl_ctrl #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (i_req),
        .o_rsp     (o_rsp),
        .o_wr_en   (wr_en),
        .o_wr_addr (wr_addr),
        .o_wr_data (wr_data),
        .o_rd_en   (rd_en),
        .o_rd_addr (rd_addr),
        .i_rd_data (rd_data)
    );

    fmacl_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (TABLE_DEPTH)
    ) u_rule_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
    import fmacl_pkg::*;

    localparam int          ACL_DEPTH      = TABLE_DEPTH_DEF;
    localparam logic [1:0]  MODE_RESERVED  = 2'd3;
    localparam logic [1:0]  KIND_UNDEFINED = 2'd3;
    localparam int          ITEMS_PER_PHASE = 200;
    localparam int          WATCHDOG_LIMIT  = 5000;
    localparam int          DRAIN_CYCLES    = 40;

    typedef struct {
        logic [1:0]  mode;
        logic [31:0] rule_address;
        logic [31:0] rule_netmask;
        logic [2:0]  rule_permits;
        logic [31:0] query_address;
        logic [1:0]  perm_kind;
        logic        user_exempt;
    } t_acl_req;

    logic i_clk = 1'b0;
    logic i_rst_n;

    fmacl_req_if req_if ();
    fmacl_rsp_if rsp_if ();

    first_match_ip_access_list_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Shadow copy of the rule list, updated in acceptance order.
    logic [31:0] acl_addr [ACL_DEPTH];
    logic [31:0] acl_mask [ACL_DEPTH];
    logic [2:0]  acl_perm [ACL_DEPTH];
    int          acl_count = 0;

    t_acl_req pending_reqs [$];
    t_result  expected_results [$];
    t_acl_req on_bus;
    t_result  expected_now;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int error_count    = 0;
    int accepted_reqs  = 0;
    int checked_results = 0;
    int granted_cnt    = 0;
    int matched_cnt    = 0;
    int dropped_cnt    = 0;
    int idle_cycles    = 0;
    int queued_items   = 0;

    function automatic t_result predict_access(input t_acl_req r);
        t_result res;
        res = '0;
        case (r.mode)
            MODE_CLEAR: begin
                acl_count = 0;
            end
            MODE_APPEND: begin
                if (acl_count >= ACL_DEPTH) begin
                    res.status = 1'b1;
                end else begin
                    acl_addr[acl_count] = r.rule_address;
                    acl_mask[acl_count] = r.rule_netmask;
                    acl_perm[acl_count] = r.rule_permits;
                    acl_count++;
                end
            end
            MODE_CHECK: begin
                if (r.user_exempt && r.perm_kind != KIND_REGISTER) begin
                    res.allowed = 1'b1;
                end else begin
                    for (int i = 0; i < acl_count; i++) begin
                        if (!res.matched && (acl_mask[i] == '0 ||
                            (acl_addr[i] & acl_mask[i]) ==
                            (r.query_address & acl_mask[i]))) begin
                            res.matched = 1'b1;
                            // An undefined kind has no permission bit and denies.
                            if (r.perm_kind <= KIND_REGISTER)
                                res.allowed = acl_perm[i][r.perm_kind];
                        end
                    end
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    // Request driver: holds an item until it is taken, then predicts its result.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
        end else begin
            if (req_if.valid && req_if.ready) begin
                expected_results.push_back(predict_access(on_bus));
                accepted_reqs++;
            end
            if (!req_if.valid || req_if.ready) begin
                if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    on_bus                <= pending_reqs[0];
                    req_if.mode           <= pending_reqs[0].mode;
                    req_if.rule_address   <= pending_reqs[0].rule_address;
                    req_if.rule_netmask   <= pending_reqs[0].rule_netmask;
                    req_if.rule_permits   <= pending_reqs[0].rule_permits;
                    req_if.query_address  <= pending_reqs[0].query_address;
                    req_if.perm_kind      <= pending_reqs[0].perm_kind;
                    req_if.user_exempt    <= pending_reqs[0].user_exempt;
                    req_if.valid          <= 1'b1;
                    pending_reqs.pop_front();
                end else begin
                    req_if.valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor with random back-pressure.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
        end else begin
            if (rsp_if.valid && rsp_if.ready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result allowed=%b matched=%b status=%b",
                             $time, rsp_if.allowed, rsp_if.matched, rsp_if.status);
                    error_count++;
                end else begin
                    expected_now = expected_results.pop_front();
                    checked_results++;
                    if (rsp_if.allowed !== expected_now.allowed) begin
                        $display("%0t: allowed mismatch, expected %b, actual %b",
                                 $time, expected_now.allowed, rsp_if.allowed);
                        error_count++;
                    end
                    if (rsp_if.matched !== expected_now.matched) begin
                        $display("%0t: matched mismatch, expected %b, actual %b",
                                 $time, expected_now.matched, rsp_if.matched);
                        error_count++;
                    end
                    if (rsp_if.status !== expected_now.status) begin
                        $display("%0t: status mismatch, expected %b, actual %b",
                                 $time, expected_now.status, rsp_if.status);
                        error_count++;
                    end
                    granted_cnt += expected_now.allowed;
                    matched_cnt += expected_now.matched;
                    dropped_cnt += expected_now.status;
                end
            end
            rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
                $display("tb: failure");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    function automatic t_acl_req make_req(input logic [1:0] mode, input logic [31:0] addr,
                                          input logic [31:0] mask, input logic [2:0] perm,
                                          input logic [31:0] query, input logic [1:0] kind,
                                          input logic exempt);
        t_acl_req r;
        r.mode          = mode;
        r.rule_address  = addr;
        r.rule_netmask  = mask;
        r.rule_permits  = perm;
        r.query_address = query;
        r.perm_kind     = kind;
        r.user_exempt   = exempt;
        return r;
    endfunction

    function automatic t_acl_req random_req();
        return make_req(2'($urandom_range(3)), $urandom, $urandom, 3'($urandom_range(7)),
                        $urandom, 2'($urandom_range(3)), 1'($urandom_range(1)));
    endfunction

    function automatic logic [31:0] random_mask();
        int pick;
        pick = $urandom_range(99);
        if (pick < 4)
            return '0;
        else if (pick < 14)
            return $urandom;
        else
            return 32'hFFFF_FFFF << (32 - $urandom_range(1, 32));
    endfunction

    task automatic queue_item(input t_acl_req r);
        pending_reqs.push_back(r);
        if (r.mode != MODE_RESERVED)
            queued_items++;
    endtask

    // A clear, a run of appends, then checks aimed mostly at the stored rules.
    task automatic queue_rule_session();
        logic [31:0] sess_addr [$];
        logic [31:0] sess_mask [$];
        t_acl_req    r;
        int          n_rules;
        int          n_checks;
        int          k;
        r = random_req();
        r.mode = MODE_CLEAR;
        queue_item(r);
        n_rules = ($urandom_range(9) == 0) ? $urandom_range(30, 34) : $urandom_range(1, 12);
        for (int i = 0; i < n_rules; i++) begin
            r = random_req();
            r.mode = MODE_APPEND;
            r.rule_netmask = random_mask();
            sess_addr.push_back(r.rule_address);
            sess_mask.push_back(r.rule_netmask);
            queue_item(r);
        end
        n_checks = $urandom_range(2, 8);
        for (int i = 0; i < n_checks; i++) begin
            r = random_req();
            r.mode = MODE_CHECK;
            r.perm_kind = ($urandom_range(9) == 0) ? KIND_UNDEFINED : 2'($urandom_range(2));
            r.user_exempt = ($urandom_range(9) < 3);
            if ($urandom_range(3) != 0) begin
                k = $urandom_range(n_rules - 1);
                r.query_address = sess_addr[k] ^ ($urandom & ~sess_mask[k]);
            end
            queue_item(r);
        end
    endtask

    task automatic run_phase(input int idle_pct, input int stall_pct);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        queued_items   = 0;
        while (queued_items < ITEMS_PER_PHASE) begin
            if ($urandom_range(99) < 85)
                queue_rule_session();
            else
                queue_item(random_req());
        end
        while (pending_reqs.size() > 0 || req_if.valid || expected_results.size() > 0)
            @(negedge i_clk);
    endtask

    initial begin
        i_rst_n              = 1'b0;
        req_if.valid         = 1'b0;
        req_if.mode          = MODE_CLEAR;
        req_if.rule_address  = '0;
        req_if.rule_netmask  = '0;
        req_if.rule_permits  = '0;
        req_if.query_address = '0;
        req_if.perm_kind     = KIND_READ;
        req_if.user_exempt   = 1'b0;
        rsp_if.ready         = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Empty list, then a subnet rule, a host rule and a catch-all rule.
        queue_item(make_req(MODE_CHECK, '0, '0, '0, '0, KIND_READ, 1'b0));
        queue_item(make_req(MODE_CHECK, '0, '0, '0, 32'hFFFF_FFFF, KIND_READ, 1'b1));
        queue_item(make_req(MODE_CHECK, '0, '0, '0, 32'h0A00_0001, KIND_REGISTER, 1'b1));
        queue_item(make_req(MODE_APPEND, 32'hC0A8_0000, 32'hFFFF_0000, 3'b001, '0,
                            KIND_READ, 1'b0));
        queue_item(make_req(MODE_APPEND, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 3'b110,
                            32'hFFFF_FFFF, KIND_UNDEFINED, 1'b1));
        queue_item(make_req(MODE_APPEND, '0, '0, 3'b111, '0, KIND_READ, 1'b0));
        queue_item(make_req(MODE_CHECK, '0, '0, '0, 32'hC0A8_1234, KIND_READ, 1'b0));
        queue_item(make_req(MODE_CHECK, '0, '0, '0, 32'hC0A8_FFFF, KIND_WRITE, 1'b0));
        queue_item(make_req(MODE_CHECK, '0, '0, '0, 32'hC0A8_0000, KIND_REGISTER, 1'b1));
        queue_item(make_req(MODE_CHECK, '0, '0, '0, 32'hFFFF_FFFF, KIND_WRITE, 1'b0));
        queue_item(make_req(MODE_CHECK, '0, '0, '0, 32'hFFFF_FFFF, KIND_REGISTER, 1'b1));
        queue_item(make_req(MODE_CHECK, '0, '0, '0, 32'h1234_5678, KIND_READ, 1'b0));
        queue_item(make_req(MODE_CHECK, '0, '0, '0, '0, KIND_UNDEFINED, 1'b0));
        queue_item(make_req(MODE_CHECK, '0, '0, '0, '0, KIND_UNDEFINED, 1'b1));
        queue_item(make_req(MODE_RESERVED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 3'b111,
                            32'hFFFF_FFFF, KIND_UNDEFINED, 1'b1));
        queue_item(make_req(MODE_CHECK, '0, '0, '0, 32'h0000_0001, KIND_WRITE, 1'b0));
        queue_item(make_req(MODE_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 3'b111,
                            32'hFFFF_FFFF, KIND_UNDEFINED, 1'b1));
        queue_item(make_req(MODE_CHECK, '0, '0, '0, 32'hC0A8_0001, KIND_READ, 1'b0));
        queue_item(make_req(MODE_APPEND, 32'h8000_0000, 32'h8000_0000, 3'b000, '0,
                            KIND_READ, 1'b0));
        queue_item(make_req(MODE_CHECK, '0, '0, '0, 32'hFFFF_FFFF, KIND_READ, 1'b0));
        queue_item(make_req(MODE_CHECK, '0, '0, '0, 32'h7FFF_FFFF, KIND_REGISTER, 1'b0));

        // The first random session always runs past a full list.
        begin
            t_acl_req r;
            r = random_req();
            r.mode = MODE_CLEAR;
            queue_item(r);
            for (int i = 0; i < ACL_DEPTH + 3; i++) begin
                r = random_req();
                r.mode = MODE_APPEND;
                r.rule_netmask = random_mask();
                queue_item(r);
            end
            r = random_req();
            r.mode = MODE_CHECK;
            queue_item(r);
        end

        run_phase(0, 0);
        run_phase(78, 0);
        run_phase(0, 78);
        run_phase(12, 12);

        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (expected_results.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time,
                     expected_results.size());
            error_count++;
        end

        $display("Covered %0d requests and %0d results over four idling and stall mixes.",
                 accepted_reqs, checked_results);
        $display("Checks granted %0d times, rule matches %0d, appends dropped on a full list %0d.",
                 granted_cnt, matched_cnt, dropped_cnt);
        if (error_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
